// ===== src/trsp_pkg.sv =====
// shared types, codes and constants of the timer record stream parser
`default_nettype none
package trsp_pkg;

  // default depth of the queue between front and back
  localparam int unsigned QueueDepthDefault = 4;

  // configuration register indexes and apb address width
  localparam int unsigned CfgAddrW = 4;
  localparam logic [1:0] RegDateCode = 2'd0;
  localparam logic [1:0] RegIntvCode = 2'd1;
  localparam logic [1:0] RegJobCode  = 2'd2;

  // trigger block lengths and job header length
  localparam logic [7:0] DateBlockLen = 8'd4;
  localparam logic [7:0] IntvBlockLen = 8'd14;
  localparam logic [8:0] JobHeadLen   = 9'd4;

  typedef enum logic [4:0] {
    TAG_ID    = 5'd0,
    TAG_TRIG  = 5'd1,
    TAG_DATE  = 5'd2,
    TAG_START = 5'd3,
    TAG_END   = 5'd4,
    TAG_WEEKS = 5'd5,
    TAG_DAYS  = 5'd6,
    TAG_HRS   = 5'd7,
    TAG_MIN   = 5'd8,
    TAG_SEC   = 5'd9,
    TAG_JOB   = 5'd10,
    TAG_DPID  = 5'd11,
    TAG_SVC   = 5'd12,
    TAG_VLEN  = 5'd13,
    TAG_VBYTE = 5'd14,
    TAG_DLEN  = 5'd15,
    TAG_DBYTE = 5'd16,
    TAG_NONE  = 5'd17
  } tag_e;

  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_OVERRUN  = 3'd1,
    ERR_DATE_LEN = 3'd2,
    ERR_INTV_LEN = 3'd3,
    ERR_BAD_TRIG = 3'd4,
    ERR_BAD_JOB  = 3'd5,
    ERR_JOB_LEN  = 3'd6
  } err_e;

  typedef struct packed {
    logic        start_of_packet;
    logic [15:0] record_count;
    logic [7:0]  data_byte;
    logic        end_of_packet;
  } in_word_t;

  typedef struct packed {
    logic [4:0]  field_tag;
    logic [31:0] field_value;
    logic [15:0] record_index;
    logic        record_done;
    logic [2:0]  error_code;
    logic        packet_done;
  } out_word_t;

  // input word with the flags the front works out
  typedef struct packed {
    in_word_t w;
    logic     len_is_date;
    logic     len_is_intv;
    logic     count_zero;
  } q_word_t;

  // configuration seen by the back
  typedef struct packed {
    logic [7:0] date_code;
    logic [7:0] intv_code;
    logic [7:0] job_code;
  } cfg_t;

endpackage
`default_nettype wire

// ===== src/trsp_front.sv =====
// front: takes input words and classifies them for the queue
`default_nettype none
module trsp_front (
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire trsp_pkg::in_word_t in_data_i,
  input  wire logic              q_full_i,
  output logic                   q_push_o,
  output trsp_pkg::q_word_t      q_word_o
);
  import trsp_pkg::*;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_word_o.w           = in_data_i;
    q_word_o.len_is_date = (in_data_i.data_byte == DateBlockLen);
    q_word_o.len_is_intv = (in_data_i.data_byte == IntvBlockLen);
    q_word_o.count_zero  = (in_data_i.record_count == 16'd0);
  end

endmodule
`default_nettype wire

// ===== src/trsp_queue.sv =====
// short queue of classified words between front and back
`default_nettype none
module trsp_queue #(
  parameter int unsigned DEPTH = trsp_pkg::QueueDepthDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire trsp_pkg::q_word_t push_word_i,
  output logic                  full_o,
  output logic                  empty_o,
  input  wire logic             pop_i,
  output trsp_pkg::q_word_t     head_o
);
  import trsp_pkg::*;

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  q_word_t         mem_q [DEPTH];
  logic [IW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [IW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == IW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == IW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("queue count above depth");

  a_count_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not grow on push");

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from an empty queue");

endmodule
`default_nettype wire

// ===== src/trsp_back.sv =====
// back: record parser state machine with the output register
`default_nettype none
module trsp_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire trsp_pkg::cfg_t    cfg_i,
  input  wire logic              q_empty_i,
  input  wire trsp_pkg::q_word_t q_head_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output trsp_pkg::out_word_t    out_data_o
);
  import trsp_pkg::*;

  typedef enum logic [4:0] {
    PH_IDLE, PH_ID, PH_TTYPE, PH_TLEN, PH_DATE, PH_ISTART, PH_IEND, PH_WEEKS,
    PH_DAYS, PH_HRS, PH_MIN, PH_SEC, PH_JTYPE, PH_JLEN, PH_DPID, PH_SVC,
    PH_VLEN, PH_VBYTE, PH_DLEN, PH_DBYTE, PH_DONE
  } phase_e;

  phase_e      phase_q, phase_d, b_ph;
  logic [3:0]  bif_q, bif_d, b_bif, g_bif;
  logic [31:0] acc_q, acc_d, b_acc, g_acc;
  logic [15:0] rl_q, rl_d, b_rl, rl_n;
  logic [15:0] cr_q, cr_d, b_cr;
  logic [7:0]  jl_q, jl_d, b_jl;
  logic [15:0] run_q, run_d, b_run, run_n;
  logic        out_valid_q, out_valid_d;
  out_word_t   out_q, out_d;

  logic        have, rec_end;
  tag_e        tag;
  logic [31:0] val;
  logic        rdone, pdone;
  err_e        ecode;
  logic [7:0]  b;
  logic        sop, eop;

  assign q_pop_o = !q_empty_i && (!out_valid_q || !out_stall_i);
  assign b   = q_head_i.w.data_byte;
  assign sop = q_head_i.w.start_of_packet;
  assign eop = q_head_i.w.end_of_packet;

  always_comb begin
    // start of packet drops the old parse
    b_ph  = sop ? PH_ID : phase_q;
    b_bif = sop ? 4'd0 : bif_q;
    b_acc = sop ? 32'd0 : acc_q;
    b_rl  = sop ? q_head_i.w.record_count : rl_q;
    b_cr  = sop ? 16'd0 : cr_q;
    b_jl  = sop ? 8'd0 : jl_q;
    b_run = sop ? 16'd0 : run_q;

    phase_d = b_ph;
    bif_d   = b_bif;
    acc_d   = b_acc;
    rl_d    = b_rl;
    cr_d    = b_cr;
    jl_d    = b_jl;
    run_d   = b_run;

    g_acc = {b_acc[23:0], b};
    g_bif = b_bif + 4'd1;
    run_n = b_run - 16'd1;
    rl_n  = b_rl - 16'd1;

    have    = 1'b0;
    rec_end = 1'b0;
    tag     = TAG_NONE;
    val     = 32'd0;
    rdone   = 1'b0;
    pdone   = 1'b0;
    ecode   = ERR_OK;

    if (sop && q_head_i.count_zero) begin
      phase_d = PH_DONE;
      have    = 1'b1;
      pdone   = 1'b1;
    end else if (b_ph != PH_IDLE && b_ph != PH_DONE) begin
      unique case (b_ph)
        PH_ID: begin
          acc_d = g_acc;
          bif_d = (g_bif >= 4'd2) ? 4'd0 : g_bif;
          if (g_bif >= 4'd2) begin
            tag = TAG_ID; val = g_acc; have = 1'b1; phase_d = PH_TTYPE;
          end
        end
        PH_TTYPE: begin
          tag = TAG_TRIG; val = {24'd0, b}; have = 1'b1;
          acc_d = {24'd0, b}; phase_d = PH_TLEN;
        end
        PH_TLEN: begin
          // date code is tested first
          if (b_acc == {24'd0, cfg_i.date_code}) begin
            if (q_head_i.len_is_date) phase_d = PH_DATE;
            else ecode = ERR_DATE_LEN;
          end else if (b_acc == {24'd0, cfg_i.intv_code}) begin
            if (q_head_i.len_is_intv) phase_d = PH_ISTART;
            else ecode = ERR_INTV_LEN;
          end else begin
            ecode = ERR_BAD_TRIG;
          end
          acc_d = 32'd0; bif_d = 4'd0;
        end
        PH_DATE, PH_ISTART, PH_IEND: begin
          acc_d = g_acc;
          bif_d = (g_bif >= 4'd4) ? 4'd0 : g_bif;
          if (g_bif >= 4'd4) begin
            val = g_acc; have = 1'b1;
            if (b_ph == PH_DATE) begin
              tag = TAG_DATE; phase_d = PH_JTYPE;
            end else if (b_ph == PH_ISTART) begin
              tag = TAG_START; phase_d = PH_IEND;
            end else begin
              tag = TAG_END; phase_d = PH_WEEKS;
            end
          end
        end
        PH_WEEKS, PH_DPID: begin
          acc_d = g_acc;
          bif_d = (g_bif >= 4'd2) ? 4'd0 : g_bif;
          if (g_bif >= 4'd2) begin
            val = {16'd0, g_acc[15:0]}; have = 1'b1;
            if (b_ph == PH_WEEKS) begin
              tag = TAG_WEEKS; phase_d = PH_DAYS;
            end else begin
              tag = TAG_DPID; phase_d = PH_SVC;
            end
          end
        end
        PH_DAYS: begin
          tag = TAG_DAYS; val = {24'd0, b}; have = 1'b1; phase_d = PH_HRS;
        end
        PH_HRS: begin
          tag = TAG_HRS; val = {24'd0, b}; have = 1'b1; phase_d = PH_MIN;
        end
        PH_MIN: begin
          tag = TAG_MIN; val = {24'd0, b}; have = 1'b1; phase_d = PH_SEC;
        end
        PH_SEC: begin
          tag = TAG_SEC; val = {24'd0, b}; have = 1'b1; phase_d = PH_JTYPE;
        end
        PH_JTYPE: begin
          tag = TAG_JOB; val = {24'd0, b}; have = 1'b1;
          acc_d = {24'd0, b}; phase_d = PH_JLEN;
        end
        PH_JLEN: begin
          if (b_acc != {24'd0, cfg_i.job_code}) begin
            ecode = ERR_BAD_JOB;
          end else begin
            jl_d = b; phase_d = PH_DPID;
          end
          acc_d = 32'd0; bif_d = 4'd0;
        end
        PH_SVC: begin
          tag = TAG_SVC; val = {24'd0, b}; have = 1'b1; phase_d = PH_VLEN;
        end
        PH_VLEN: begin
          // job block length counts the four header bytes
          if ({1'b0, b_jl} != ({1'b0, b} + JobHeadLen)) begin
            ecode = ERR_JOB_LEN;
          end else begin
            tag = TAG_VLEN; val = {24'd0, b}; have = 1'b1;
            run_d = {8'd0, b};
            acc_d = 32'd0; bif_d = 4'd0;
            phase_d = (b == 8'd0) ? PH_DLEN : PH_VBYTE;
          end
        end
        PH_VBYTE: begin
          tag = TAG_VBYTE; val = {24'd0, b}; have = 1'b1;
          run_d = run_n;
          if (run_n == 16'd0) begin
            acc_d = 32'd0; bif_d = 4'd0; phase_d = PH_DLEN;
          end
        end
        PH_DLEN: begin
          acc_d = g_acc;
          bif_d = (g_bif >= 4'd2) ? 4'd0 : g_bif;
          if (g_bif >= 4'd2) begin
            tag = TAG_DLEN; val = {16'd0, g_acc[15:0]}; have = 1'b1;
            run_d = g_acc[15:0];
            if (g_acc[15:0] == 16'd0) rec_end = 1'b1;
            else phase_d = PH_DBYTE;
          end
        end
        PH_DBYTE: begin
          tag = TAG_DBYTE; val = {24'd0, b}; have = 1'b1;
          run_d = run_n;
          if (run_n == 16'd0) rec_end = 1'b1;
        end
        default: begin
        end
      endcase

      if (rec_end) begin
        rdone = 1'b1;
        rl_d  = rl_n;
        acc_d = 32'd0; bif_d = 4'd0;
        if (rl_n == 16'd0) begin
          pdone = 1'b1; phase_d = PH_DONE;
        end else begin
          cr_d = b_cr + 16'd1; phase_d = PH_ID;
        end
      end

      // buffer ended with records still owed
      if (ecode == ERR_OK && eop && phase_d != PH_DONE) ecode = ERR_OVERRUN;
      if (ecode != ERR_OK) begin
        tag = TAG_NONE; val = 32'd0; rdone = 1'b0; pdone = 1'b1; have = 1'b1;
        phase_d = PH_IDLE;
      end
    end

    out_d.field_tag    = tag;
    out_d.field_value  = val;
    out_d.record_index = (sop && q_head_i.count_zero) ? 16'd0 : b_cr;
    out_d.record_done  = rdone;
    out_d.error_code   = ecode;
    out_d.packet_done  = pdone;

    if (q_pop_o) out_valid_d = have;
    else if (!out_stall_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      bif_q       <= 4'd0;
      acc_q       <= 32'd0;
      rl_q        <= 16'd0;
      cr_q        <= 16'd0;
      jl_q        <= 8'd0;
      run_q       <= 16'd0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (q_pop_o && have) begin
        out_q <= out_d;
      end
      if (q_pop_o) begin
        phase_q <= phase_d;
        bif_q   <= bif_d;
        acc_q   <= acc_d;
        rl_q    <= rl_d;
        cr_q    <= cr_d;
        jl_q    <= jl_d;
        run_q   <= run_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_err_ends_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.error_code != ERR_OK) |-> out_q.packet_done)
    else $error("error word without packet end");

  a_err_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && have && ecode != ERR_OK) |=> (phase_q == PH_IDLE))
    else $error("parser not idle after error");

  a_none_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.field_tag == TAG_NONE) |-> (out_q.field_value == 32'd0))
    else $error("no-field word carries a value");

endmodule
`default_nettype wire

// ===== src/timer_record_stream_parser_core.sv =====
// top level of the timer record stream parser with its register port
`default_nettype none
// Timer record stream parser. Payload bytes of a response come in one word per
// cycle while the input is not stalled, with start_of_packet and the record
// count on the first byte and end_of_packet on the last. Each timer record (id,
// date or interval trigger, set-datapoint job, description) is decoded into
// tagged field words on the output; the word that ends a record carries
// record_done, and the last word of a packet carries packet_done. The first
// error gives a no-field word with the error code and packet_done, and the rest
// of the packet is dropped until the next start. Throughput is one input word
// per cycle while the output is not stalled, set by the back's parser state
// machine, which retires one byte per cycle. An accepted byte is written into
// the queue and then parsed from the queue head into the output register.
// Bytes that complete no field give no output word. The queue between front
// and back holds QUEUE_DEPTH words, so the input keeps flowing for that many
// words while the output stalls. There is no clearing pass after reset. Trigger
// and job codes are set through the apb port at byte addresses 0, 4 and 8; the
// user must write them only while the block is idle, which it does not enforce.
module timer_record_stream_parser_core #(
  parameter int unsigned QUEUE_DEPTH = trsp_pkg::QueueDepthDefault
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // input byte channel
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire trsp_pkg::in_word_t             in_data_i,
  // result channel
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output trsp_pkg::out_word_t                 out_data_o,
  // register port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [trsp_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import trsp_pkg::*;

  // configuration registers
  logic [7:0] date_code_q, intv_code_q, job_code_q;
  logic       cfg_wr;
  cfg_t       cfg;

  // queue hookup
  logic       q_push, q_pop, q_full, q_empty;
  q_word_t    q_in, q_head;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      date_code_q <= 8'd1;
      intv_code_q <= 8'd2;
      job_code_q  <= 8'd1;
    end else if (cfg_wr) begin
      // writes beyond the register list are dropped
      unique case (paddr[3:2])
        RegDateCode: date_code_q <= pwdata[7:0];
        RegIntvCode: intv_code_q <= pwdata[7:0];
        RegJobCode:  job_code_q  <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (paddr[3:2])
      RegDateCode: prdata = {24'd0, date_code_q};
      RegIntvCode: prdata = {24'd0, intv_code_q};
      RegJobCode:  prdata = {24'd0, job_code_q};
      default:     prdata = 32'd0;
    endcase
  end

  always_comb begin
    cfg.date_code = date_code_q;
    cfg.intv_code = intv_code_q;
    cfg.job_code  = job_code_q;
  end

  // front: accept and classify
  trsp_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_word_o   (q_in)
  );

  // decoupling queue
  trsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_word_i (q_in),
    .full_o      (q_full),
    .empty_o     (q_empty),
    .pop_i       (q_pop),
    .head_o      (q_head)
  );

  // back: parser and output register
  trsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// self-checking testbench of the timer record stream parser core
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import trsp_pkg::*;

  // longest stretch with no word moving on either channel before the run is
  // declared hung: the receiver hold-off, bursts of idling on both sides, the
  // settling wait before register writes and the register accesses themselves
  // stay far below this
  localparam int StuckLimit = 2000;
  // length of the receiver hold-off that fills the block and stalls its input
  localparam int HoldCycles = 64;
  // cycles allowed after the last expected word before the block is idle
  localparam int SettleCycles = 8;
  localparam int DrainCycles = 20;

  // parse phases of the prediction
  typedef enum logic [4:0] {
    ST_IDLE, ST_ID, ST_TTYPE, ST_TLEN, ST_DATE, ST_ISTART, ST_IEND, ST_WEEKS,
    ST_DAYS, ST_HRS, ST_MIN, ST_SEC, ST_JTYPE, ST_JLEN, ST_DPID, ST_SVC,
    ST_VLEN, ST_VBYTE, ST_DLEN, ST_DBYTE, ST_DONE
  } parse_st_e;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  // byte channel into the block
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  // field channel out of the block
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;
  // register port
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  timer_record_stream_parser_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // ---------------------------------------------------------------------------
  // prediction: trigger and job codes as last written, plus the parse state
  // ---------------------------------------------------------------------------
  logic [7:0]  code_date = 8'd1;
  logic [7:0]  code_intv = 8'd2;
  logic [7:0]  code_job  = 8'd1;

  parse_st_e   st = ST_IDLE;
  logic [3:0]  nbyte = '0;      // bytes gathered of the current multi-byte field
  logic [31:0] acc = '0;        // field being gathered, or the pending type byte
  logic [15:0] recs_left = '0;
  logic [15:0] cur_rec = '0;
  logic [7:0]  job_len = '0;
  logic [15:0] run_left = '0;   // value or description bytes still to come

  // field words still owed by the block, oldest first
  out_word_t pending_fields[$];

  int mismatches = 0;
  int bytes_sent = 0;

  // shift one byte into a big-endian field, true once n bytes are in
  function automatic bit take_byte(input logic [7:0] b, input logic [3:0] n);
    acc = {acc[23:0], b};
    nbyte = nbyte + 4'd1;
    if (nbyte >= n) begin
      nbyte = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // advance the parse by one accepted byte; true when it yields a field word
  function automatic bit predict_field(input in_word_t w, output out_word_t r);
    tag_e        tag;
    err_e        err;
    logic [31:0] val;
    logic [15:0] idx;
    logic [7:0]  b;
    bit          have, rec_end, rdone, pdone;
    tag = TAG_NONE;
    err = ERR_OK;
    val = '0;
    have = 1'b0;
    rec_end = 1'b0;
    rdone = 1'b0;
    pdone = 1'b0;
    b = w.data_byte;
    r = '0;
    if (w.start_of_packet) begin
      st = ST_ID;
      nbyte = '0;
      acc = '0;
      recs_left = w.record_count;
      cur_rec = '0;
      job_len = '0;
      run_left = '0;
      // an empty record list is answered at once
      if (w.record_count == 16'd0) begin
        st = ST_DONE;
        r.field_tag = TAG_NONE;
        r.packet_done = 1'b1;
        return 1'b1;
      end
    end
    if (st == ST_IDLE || st == ST_DONE) return 1'b0;
    idx = cur_rec;
    case (st)
      ST_ID: if (take_byte(b, 4'd2)) begin
        tag = TAG_ID; val = acc; have = 1'b1; st = ST_TTYPE;
      end
      ST_TTYPE: begin
        tag = TAG_TRIG; val = {24'd0, b}; have = 1'b1; acc = {24'd0, b}; st = ST_TLEN;
      end
      ST_TLEN: begin
        // date code wins when both codes are equal
        if (acc == {24'd0, code_date}) begin
          if (b == DateBlockLen) st = ST_DATE;
          else err = ERR_DATE_LEN;
        end else if (acc == {24'd0, code_intv}) begin
          if (b == IntvBlockLen) st = ST_ISTART;
          else err = ERR_INTV_LEN;
        end else begin
          err = ERR_BAD_TRIG;
        end
        acc = '0;
        nbyte = '0;
      end
      ST_DATE: if (take_byte(b, 4'd4)) begin
        tag = TAG_DATE; val = acc; have = 1'b1; st = ST_JTYPE;
      end
      ST_ISTART: if (take_byte(b, 4'd4)) begin
        tag = TAG_START; val = acc; have = 1'b1; st = ST_IEND;
      end
      ST_IEND: if (take_byte(b, 4'd4)) begin
        tag = TAG_END; val = acc; have = 1'b1; st = ST_WEEKS;
      end
      ST_WEEKS: if (take_byte(b, 4'd2)) begin
        tag = TAG_WEEKS; val = {16'd0, acc[15:0]}; have = 1'b1; st = ST_DAYS;
      end
      ST_DAYS: begin tag = TAG_DAYS; val = {24'd0, b}; have = 1'b1; st = ST_HRS; end
      ST_HRS:  begin tag = TAG_HRS;  val = {24'd0, b}; have = 1'b1; st = ST_MIN; end
      ST_MIN:  begin tag = TAG_MIN;  val = {24'd0, b}; have = 1'b1; st = ST_SEC; end
      ST_SEC:  begin tag = TAG_SEC;  val = {24'd0, b}; have = 1'b1; st = ST_JTYPE; end
      ST_JTYPE: begin
        tag = TAG_JOB; val = {24'd0, b}; have = 1'b1; acc = {24'd0, b}; st = ST_JLEN;
      end
      ST_JLEN: begin
        if (acc != {24'd0, code_job}) begin
          err = ERR_BAD_JOB;
        end else begin
          job_len = b;
          st = ST_DPID;
        end
        acc = '0;
        nbyte = '0;
      end
      ST_DPID: if (take_byte(b, 4'd2)) begin
        tag = TAG_DPID; val = {16'd0, acc[15:0]}; have = 1'b1; st = ST_SVC;
      end
      ST_SVC: begin tag = TAG_SVC; val = {24'd0, b}; have = 1'b1; st = ST_VLEN; end
      ST_VLEN: begin
        // nine bits, so a value length near 255 cannot wrap onto a short block
        if ({1'b0, job_len} != {1'b0, b} + JobHeadLen) begin
          err = ERR_JOB_LEN;
        end else begin
          tag = TAG_VLEN;
          val = {24'd0, b};
          have = 1'b1;
          run_left = {8'd0, b};
          acc = '0;
          nbyte = '0;
          st = (b == 8'd0) ? ST_DLEN : ST_VBYTE;
        end
      end
      ST_VBYTE: begin
        tag = TAG_VBYTE; val = {24'd0, b}; have = 1'b1;
        run_left = run_left - 16'd1;
        if (run_left == 16'd0) begin
          acc = '0;
          nbyte = '0;
          st = ST_DLEN;
        end
      end
      ST_DLEN: if (take_byte(b, 4'd2)) begin
        tag = TAG_DLEN; val = {16'd0, acc[15:0]}; have = 1'b1;
        run_left = acc[15:0];
        if (run_left == 16'd0) rec_end = 1'b1;
        else st = ST_DBYTE;
      end
      ST_DBYTE: begin
        tag = TAG_DBYTE; val = {24'd0, b}; have = 1'b1;
        run_left = run_left - 16'd1;
        if (run_left == 16'd0) rec_end = 1'b1;
      end
      default: ;
    endcase

    if (rec_end) begin
      rdone = 1'b1;
      recs_left = recs_left - 16'd1;
      acc = '0;
      nbyte = '0;
      if (recs_left == 16'd0) begin
        pdone = 1'b1;
        st = ST_DONE;
      end else begin
        cur_rec = cur_rec + 16'd1;
        st = ST_ID;
      end
    end

    // buffer ends while records are still owed; a check on the byte wins
    if (err == ERR_OK && w.end_of_packet && st != ST_DONE) err = ERR_OVERRUN;
    if (err != ERR_OK) begin
      tag = TAG_NONE;
      val = '0;
      rdone = 1'b0;
      pdone = 1'b1;
      have = 1'b1;
      st = ST_IDLE;
    end
    if (!have) return 1'b0;
    r.field_tag = tag;
    r.field_value = val;
    r.record_index = idx;
    r.record_done = rdone;
    r.error_code = err;
    r.packet_done = pdone;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // checking of the field channel
  // ---------------------------------------------------------------------------
  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) note_mismatch($sformatf("%s expected %0h got %0h", name, want, got));
  endfunction

  // every accepted word is matched against the oldest owed word
  always @(posedge clk) begin : check_fields
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_fields.size() == 0) begin
        note_mismatch($sformatf("word %h with nothing owed", out_data));
      end else begin
        want = pending_fields.pop_front();
        compare_field("field_tag",    32'(want.field_tag),    32'(out_data.field_tag));
        compare_field("field_value",  want.field_value,       out_data.field_value);
        compare_field("record_index", 32'(want.record_index), 32'(out_data.record_index));
        compare_field("record_done",  32'(want.record_done),  32'(out_data.record_done));
        compare_field("error_code",   32'(want.error_code),   32'(out_data.error_code));
        compare_field("packet_done",  32'(want.packet_done),  32'(out_data.packet_done));
      end
    end
  end

  // ends a hung run: counts cycles in which no word moves on either channel
  int stuck_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == StuckLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stall bursts, a long hold-off on request, none at the tail
  // ---------------------------------------------------------------------------
  logic quiet_tail = 1'b0;   // no idling on either side once set
  int   hold_gen = 0;        // bumped by a test to ask for one long hold-off
  int   hold_seen = 0;
  int   hold_left = 0;
  int   burst_left = 0;

  always @(negedge clk) begin
    if (hold_seen != hold_gen) begin
      hold_seen = hold_gen;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (burst_left > 0) begin
      burst_left--;
      out_stall <= 1'b1;
    end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
      burst_left = $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------
  bit no_gaps = 1'b0;

  // called and returns at a falling edge; offers one word until it is taken
  task automatic send_word(input in_word_t w);
    out_word_t r;
    int gap;
    gap = 0;
    if (!no_gaps && !quiet_tail && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    if (predict_field(w, r)) pending_fields.insert(pending_fields.size(), r);
    bytes_sent++;
    @(negedge clk);
  endtask

  // drop valid and wait until every owed word is out and the block settles
  task automatic wait_idle(input int settle);
    in_valid <= 1'b0;
    while (pending_fields.size() != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // one apb transfer: setup cycle, access cycle, then an idle cycle
  task automatic apb_transfer(input bit wr, input logic [1:0] idx, input logic [7:0] wdata,
                              output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, wdata};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // read a code register back and hold it against the last value written
  task automatic check_code(input logic [1:0] idx);
    logic [31:0] rd;
    logic [7:0]  want;
    apb_transfer(1'b0, idx, 8'd0, rd);
    want = 8'd0;
    case (idx)
      RegDateCode: want = code_date;
      RegIntvCode: want = code_intv;
      RegJobCode:  want = code_job;
      default: ;
    endcase
    if (rd[7:0] !== want)
      note_mismatch($sformatf("register %0d expected %0h got %0h", idx, want, rd[7:0]));
  endtask

  task automatic write_code(input logic [1:0] idx, input logic [7:0] value);
    logic [31:0] unused;
    apb_transfer(1'b1, idx, value, unused);
    case (idx)
      RegDateCode: code_date = value;
      RegIntvCode: code_intv = value;
      RegJobCode:  code_job = value;
      default: ;
    endcase
    check_code(idx);
  endtask

  task automatic set_codes(input logic [7:0] d, input logic [7:0] i, input logic [7:0] j);
    wait_idle(SettleCycles);
    write_code(RegDateCode, d);
    write_code(RegIntvCode, i);
    write_code(RegJobCode, j);
  endtask

  // ---------------------------------------------------------------------------
  // packet building
  // ---------------------------------------------------------------------------
  logic [7:0] pkt[$];
  // positions in the last record built, for targeted damage
  int trig_type_at, job_type_at, vlen_at;

  // append one byte at the end of the packet
  function automatic void append_byte(input logic [7:0] v);
    pkt.insert(pkt.size(), v);
  endfunction

  function automatic void load_bytes(input logic [31:0] bytes, input int n);
    int k;
    pkt.delete();
    for (k = n - 1; k >= 0; k--) append_byte(bytes[8*k +: 8]);
  endfunction

  function automatic void push_random(input int n);
    int k;
    for (k = 0; k < n; k++) append_byte(8'($urandom));
  endfunction

  // mostly short value and description runs, now and then longer ones
  function automatic int pick_run();
    if ($urandom_range(0, 9) == 0) return $urandom_range(4, 24);
    return $urandom_range(0, 3);
  endfunction

  // one well-formed record under the current codes
  function automatic void add_record(input bit intv, input int vlen, input int dlen);
    logic [15:0] dl;
    dl = 16'(dlen);
    push_random(2);
    trig_type_at = pkt.size();
    append_byte(intv ? code_intv : code_date);
    append_byte(intv ? IntvBlockLen : DateBlockLen);
    push_random(intv ? 14 : 4);
    job_type_at = pkt.size();
    append_byte(code_job);
    append_byte(8'(vlen) + 8'(JobHeadLen));
    push_random(3);
    vlen_at = pkt.size();
    append_byte(8'(vlen));
    push_random(vlen);
    append_byte(dl[15:8]);
    append_byte(dl[7:0]);
    push_random(dlen);
  endfunction

  // start flag and count on the first byte, the count bits random elsewhere
  task automatic send_packet(input logic [15:0] count, input bit with_eop);
    in_word_t w;
    int k;
    for (k = 0; k < pkt.size(); k++) begin
      w.start_of_packet = (k == 0);
      w.record_count = (k == 0) ? count : 16'($urandom);
      w.data_byte = pkt[k];
      w.end_of_packet = with_eop && (k == pkt.size() - 1);
      send_word(w);
    end
  endtask

  // about half the packets are clean, the rest damaged in one targeted way
  task automatic send_random_packet();
    int nrec, kind, r, n;
    logic [15:0] count;
    bit with_eop;
    pkt.delete();
    nrec = $urandom_range(1, 3);
    for (r = 0; r < nrec; r++) add_record(1'($urandom_range(0, 1)), pick_run(), pick_run());
    count = 16'(nrec);
    with_eop = 1'b1;
    kind = $urandom_range(0, 23);
    case (kind)
      0: pkt[trig_type_at] = 8'($urandom);
      1: pkt[trig_type_at + 1] = 8'($urandom);
      2: pkt[job_type_at] = 8'($urandom);
      3: pkt[job_type_at + 1] = 8'($urandom);
      4: begin
        // value length near 255 whose block length wraps in eight bits
        pkt[vlen_at] = 8'($urandom_range(252, 255));
        pkt[job_type_at + 1] = pkt[vlen_at] + 8'(JobHeadLen);
      end
      5, 6: begin
        // cut short: with end flag an overrun, without it the next start restarts
        n = $urandom_range(1, pkt.size() - 1);
        while (pkt.size() > n) void'(pkt.pop_back());
        with_eop = (kind == 5);
      end
      7: count = 16'(nrec + $urandom_range(1, 2));
      8: count = 16'($urandom);
      9: count = 16'($urandom_range(1, nrec));
      10: begin
        // stray bytes between packets
        n = $urandom_range(1, 3);
        for (r = 0; r < n; r++)
          send_word({1'b0, 16'($urandom), 8'($urandom), 1'($urandom_range(0, 1))});
      end
      default: ;
    endcase
    send_packet(count, with_eop);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // codes read back their reset values
  task automatic test_reset_values();
    check_code(RegDateCode);
    check_code(RegIntvCode);
    check_code(RegJobCode);
  endtask

  // short packets for each special case, under the reset codes
  task automatic test_special_cases();
    // zero records: one summary word, then a stray byte is ignored
    load_bytes(32'h00, 1);
    send_packet(16'd0, 1'b0);
    send_word({1'b0, 16'hFFFF, 8'hFF, 1'b1});
    // a record left open, dropped by the next start
    load_bytes(32'hAB, 1);
    send_packet(16'd1, 1'b0);
    // date block of wrong length, on the last byte: the check beats overrun
    load_bytes({8'h00, 8'h00, code_date, 8'h05}, 4);
    send_packet(16'd1, 1'b1);
    // interval block of wrong length
    load_bytes({8'hFF, 8'hFF, code_intv, DateBlockLen}, 4);
    send_packet(16'd1, 1'b0);
    // type byte matching neither trigger code
    load_bytes({8'h12, 8'h34, code_intv + 8'd1, DateBlockLen}, 4);
    send_packet(16'd2, 1'b0);
    // buffer ends on the very first byte of a huge record list
    load_bytes(32'hFF, 1);
    send_packet(16'hFFFF, 1'b1);
  endtask

  task automatic test_random_traffic(input int n);
    int target;
    target = bytes_sent + n;
    while (bytes_sent < target) send_random_packet();
  endtask

  // receiver holds off while the sender keeps offering a long packet
  task automatic test_backpressure();
    int r;
    no_gaps = 1'b1;
    hold_gen <= hold_gen + 1;
    pkt.delete();
    for (r = 0; r < 3; r++) add_record(r[0], 2, 3);
    send_packet(16'd3, 1'b1);
    no_gaps = 1'b0;
  endtask

  // extreme codes, then equal trigger codes where the date code must win
  task automatic test_code_settings();
    set_codes(8'h00, 8'hFF, 8'hFF);
    test_random_traffic(80);
    set_codes(8'hFF, 8'h00, 8'h00);
    test_random_traffic(80);
    set_codes(8'h5A, 8'h5A, 8'h33);
    test_random_traffic(40);
  endtask

  // random codes and traffic with no idling on either side
  task automatic test_quiet_tail();
    logic [7:0] d, i;
    d = 8'($urandom);
    i = 8'($urandom);
    if (i == d) i = d ^ 8'h01;
    set_codes(d, i, 8'($urandom));
    quiet_tail <= 1'b1;
    test_random_traffic(100);
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_values();
    test_special_cases();
    test_random_traffic(100);
    test_backpressure();
    test_code_settings();
    test_quiet_tail();
    wait_idle(DrainCycles);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire

// ===== timer_record_stream_parser_core.f =====
src/trsp_pkg.sv
src/trsp_front.sv
src/trsp_queue.sv
src/trsp_back.sv
src/timer_record_stream_parser_core.sv
tb/tb_top.sv
